// ===== rtl/core/bsfb_pkg.sv =====
package bsfb_pkg;

  // Default panel geometry and limits
  localparam int PanelWidthDef  = 64;
  localparam int PanelHeightDef = 32;
  localparam int MaxPendingDef  = 64;
  localparam int MaxBrushDef    = 8;

  // Field widths fixed by the command word
  localparam int ColorW = 16;
  localparam int PosW   = 8;
  localparam int SizeW  = 4;

  // Command codes
  typedef enum logic [1:0] {
    CMD_STAMP = 2'd0,
    CMD_FLUSH = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } bsfb_cmd_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_STAMP,
    ST_READ,
    ST_DONE
  } bsfb_state_e;

  // Command word
  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [PosW-1:0]  pos_x;
    logic signed [PosW-1:0]  pos_y;
    logic [ColorW-1:0]       paint_color;
    logic [SizeW-1:0]        brush_size;
  } bsfb_in_t;

  // Result word
  typedef struct packed {
    logic              accepted;
    logic              dirty_valid;
    logic [5:0]        dirty_min_x;
    logic [5:0]        dirty_max_x;
    logic [4:0]        dirty_min_y;
    logic [4:0]        dirty_max_y;
    logic [ColorW-1:0] pixel_value;
  } bsfb_out_t;

endpackage

// ===== rtl/core/brush_stamp_framebuffer_core.sv =====
// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_ready_o    in_word_i   (bsfb_in_t)
// out       output     out_valid_o / out_ready_i  out_word_o  (bsfb_out_t)
// cfg       input      cfg_we_i                   cfg_wdata_i (clear color)
//
// One command at a time; the frame store has one write and one read port.
// Stamp: paints s*s pixels (s = clamped brush size, 0 when dropped; one pixel a cycle),
// then hands the word to the output register.
// Flush goes to the hand-off; read adds a store read (not off the panel); clear writes W*H entries (one entry a cycle).
// After reset a pass over all W*H entries zeroes the store; no command is taken then.
// A new command is taken while the previous word waits at the output; it then holds until that word leaves.
module brush_stamp_framebuffer_core #(
  parameter int PANEL_WIDTH  = bsfb_pkg::PanelWidthDef,
  parameter int PANEL_HEIGHT = bsfb_pkg::PanelHeightDef,
  parameter int MAX_PENDING  = bsfb_pkg::MaxPendingDef,
  parameter int MAX_BRUSH    = bsfb_pkg::MaxBrushDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  bsfb_pkg::bsfb_in_t          in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output bsfb_pkg::bsfb_out_t         out_word_o,
  input  logic                        cfg_we_i,
  input  logic [bsfb_pkg::ColorW-1:0] cfg_wdata_i
);
  import bsfb_pkg::*;

  localparam int Depth = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int XW    = $clog2(PANEL_WIDTH);
  localparam int YW    = $clog2(PANEL_HEIGHT);
  localparam int PW    = $clog2(MAX_PENDING + 1);
  localparam logic signed [9:0] WidthS  = 10'(PANEL_WIDTH);
  localparam logic signed [9:0] HeightS = 10'(PANEL_HEIGHT);

  // Linear store address of an on-panel pixel
  function automatic logic [AW-1:0] pix_addr(input logic [YW-1:0] yi,
                                              input logic [XW-1:0] xi);
    logic [AW-1:0] base;
    base = AW'(AW'(yi) * AW'(PANEL_WIDTH));
    return base + AW'(xi);
  endfunction

  bsfb_state_e           state_q, state_d;
  logic [ColorW-1:0]     clr_color_q;
  logic [ColorW-1:0]     fill_q, fill_d;
  logic [ColorW-1:0]     color_q, color_d;
  logic [SizeW-1:0]      size_q, size_d;
  logic [SizeW-1:0]      dx_q, dx_d, dy_q, dy_d;
  logic signed [8:0]     x0_q, x0_d, y0_q, y0_d;
  logic [PW-1:0]         pend_q, pend_d;
  logic [XW-1:0]         box_min_x_q, box_min_x_d, box_max_x_q, box_max_x_d;
  logic [YW-1:0]         box_min_y_q, box_min_y_d, box_max_y_q, box_max_y_d;
  logic                  box_any_q, box_any_d;
  logic [AW-1:0]         idx_q, idx_d;
  logic                  report_q, report_d;
  bsfb_out_t             res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  bsfb_out_t             out_word_q, out_word_d;

  // Frame store ports
  logic [ColorW-1:0]     mem [Depth];
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [ColorW-1:0]     mem_wdata, rdata_q;

  // Stamp pixel and command decode helpers
  logic signed [9:0]     xx, yy, pxs, pys;
  logic                  pix_in, rd_in, in_acc;
  logic [SizeW-1:0]      size_c, half_c;
  logic [XW-1:0]         xi;
  logic [YW-1:0]         yi;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  assign xx     = 10'(x0_q) + $signed({6'b0, dx_q});
  assign yy     = 10'(y0_q) + $signed({6'b0, dy_q});
  assign pix_in = (xx >= 0) && (xx < WidthS) && (yy >= 0) && (yy < HeightS);
  assign xi     = xx[XW-1:0];
  assign yi     = yy[YW-1:0];

  assign pxs   = 10'(in_word_i.pos_x);
  assign pys   = 10'(in_word_i.pos_y);
  assign rd_in = (pxs >= 0) && (pxs < WidthS) && (pys >= 0) && (pys < HeightS);

  // Clamp the brush and find the offset of its top-left corner
  assign size_c = (in_word_i.brush_size > SizeW'(MAX_BRUSH)) ? SizeW'(MAX_BRUSH)
                                                              : in_word_i.brush_size;
  assign half_c = (size_c == '0) ? '0 : ((size_c - SizeW'(1)) >> 1);

  // Memory write and read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Sequencer: next state, store accesses and result
  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    color_d     = color_q;
    size_d      = size_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    pend_d      = pend_q;
    box_min_x_d = box_min_x_q;
    box_max_x_d = box_max_x_q;
    box_min_y_d = box_min_y_q;
    box_max_y_d = box_max_y_q;
    box_any_d   = box_any_q;
    idx_d       = idx_q;
    report_d    = report_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_word_d  = out_word_q;
    mem_we      = 1'b0;
    mem_waddr   = pix_addr(yi, xi);
    mem_wdata   = color_q;
    mem_re      = 1'b0;
    mem_raddr   = pix_addr(pys[YW-1:0], pxs[XW-1:0]);

    unique case (state_q)
      // Fill every entry with the latched color
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = fill_q;
        idx_d     = idx_q + AW'(1);
        if (idx_q == AW'(Depth - 1)) begin
          idx_d   = '0;
          state_d = report_q ? ST_DONE : ST_IDLE;
        end
      end

      // Take a command word and dispatch it
      ST_IDLE: begin
        if (in_acc) begin
          res_d   = '0;
          state_d = ST_DONE;
          unique case (bsfb_cmd_e'(in_word_i.cmd))
            CMD_STAMP: begin
              if (pend_q < PW'(MAX_PENDING)) begin
                res_d.accepted = 1'b1;
                pend_d  = pend_q + PW'(1);
                color_d = in_word_i.paint_color;
                size_d  = size_c;
                dx_d    = '0;
                dy_d    = '0;
                x0_d    = 9'(in_word_i.pos_x) - $signed({5'b0, half_c});
                y0_d    = 9'(in_word_i.pos_y) - $signed({5'b0, half_c});
                if (size_c != '0) begin
                  state_d = ST_STAMP;
                end
              end
            end
            CMD_FLUSH: begin
              res_d.accepted = 1'b1;
              if (box_any_q) begin
                res_d.dirty_valid = 1'b1;
                res_d.dirty_min_x = 6'(box_min_x_q);
                res_d.dirty_max_x = 6'(box_max_x_q);
                res_d.dirty_min_y = 5'(box_min_y_q);
                res_d.dirty_max_y = 5'(box_max_y_q);
              end
              pend_d      = '0;
              box_min_x_d = XW'(PANEL_WIDTH - 1);
              box_max_x_d = '0;
              box_min_y_d = YW'(PANEL_HEIGHT - 1);
              box_max_y_d = '0;
              box_any_d   = 1'b0;
            end
            CMD_CLEAR: begin
              res_d.accepted = 1'b1;
              fill_d      = clr_color_q;
              idx_d       = '0;
              report_d    = 1'b1;
              pend_d      = '0;
              box_min_x_d = XW'(PANEL_WIDTH - 1);
              box_max_x_d = '0;
              box_min_y_d = YW'(PANEL_HEIGHT - 1);
              box_max_y_d = '0;
              box_any_d   = 1'b0;
              state_d     = ST_SWEEP;
            end
            CMD_READ: begin
              if (rd_in) begin
                res_d.accepted = 1'b1;
                mem_re  = 1'b1;
                state_d = ST_READ;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      // Paint one pixel a cycle, row by row, and widen the box
      ST_STAMP: begin
        if (pix_in) begin
          mem_we    = 1'b1;
          box_any_d = 1'b1;
          if (xi < box_min_x_q) box_min_x_d = xi;
          if (xi > box_max_x_q) box_max_x_d = xi;
          if (yi < box_min_y_q) box_min_y_d = yi;
          if (yi > box_max_y_q) box_max_y_d = yi;
        end
        if (dx_q == size_q - SizeW'(1)) begin
          dx_d = '0;
          dy_d = dy_q + SizeW'(1);
          if (dy_q == size_q - SizeW'(1)) begin
            state_d = ST_DONE;
          end
        end else begin
          dx_d = dx_q + SizeW'(1);
        end
      end

      // Pick up the read data
      ST_READ: begin
        res_d.pixel_value = rdata_q;
        state_d           = ST_DONE;
      end

      // Hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_word_d  = res_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      clr_color_q <= '0;
      fill_q      <= '0;
      pend_q      <= '0;
      box_min_x_q <= XW'(PANEL_WIDTH - 1);
      box_max_x_q <= '0;
      box_min_y_q <= YW'(PANEL_HEIGHT - 1);
      box_max_y_q <= '0;
      box_any_q   <= 1'b0;
      idx_q       <= '0;
      report_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        clr_color_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      pend_q      <= pend_d;
      box_min_x_q <= box_min_x_d;
      box_max_x_q <= box_max_x_d;
      box_min_y_q <= box_min_y_d;
      box_max_y_q <= box_max_y_d;
      box_any_q   <= box_any_d;
      idx_q       <= idx_d;
      report_q    <= report_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    color_q    <= color_d;
    size_q     <= size_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    x0_q       <= x0_d;
    y0_q       <= y0_d;
    res_q      <= res_d;
    out_word_q <= out_word_d;
  end

  // Checks
  a_no_write_when_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !mem_we)
    else $error("store written while taking commands");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PW'(MAX_PENDING))
    else $error("pending count above limit");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_any_q |-> (box_min_x_q <= box_max_x_q) && (box_min_y_q <= box_max_y_q))
    else $error("dirty box inverted");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("second command taken while busy");

endmodule
